/* rtl/smea_pkg.sv */
// ----------------------------------------------------------------------------
// smea_pkg
// shared types and constants of the spin matrix element accumulator
// ----------------------------------------------------------------------------
package smea_pkg;

  // fixed field widths
  localparam int unsigned DV_W   = 24;
  localparam int unsigned OUT_W  = 48;
  localparam int unsigned N_SMP  = 8;
  localparam int unsigned N_OUT  = 6;
  localparam int unsigned TAG_W  = 3;
  localparam int unsigned N_PROD = 16;

  // sample slots in a queue entry
  localparam int unsigned SMP_LUR = 0;
  localparam int unsigned SMP_LUI = 1;
  localparam int unsigned SMP_LDR = 2;
  localparam int unsigned SMP_LDI = 3;
  localparam int unsigned SMP_RUR = 4;
  localparam int unsigned SMP_RUI = 5;
  localparam int unsigned SMP_RDR = 6;
  localparam int unsigned SMP_RDI = 7;

  // result slots, real parts on even slots
  localparam int unsigned OUT_XR = 0;
  localparam int unsigned OUT_XI = 1;
  localparam int unsigned OUT_YR = 2;
  localparam int unsigned OUT_YI = 3;
  localparam int unsigned OUT_ZR = 4;
  localparam int unsigned OUT_ZI = 5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_ELEMENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_MODE      = 1'b1;
  localparam logic [DV_W-1:0] DV_RESET = 24'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ACC,
    ST_WAIT,
    ST_SCALE,
    ST_DRAIN
  } smea_state_e;

  typedef struct packed {
    logic vld;
    logic last;
  } smea_q_ctl_t;

  typedef struct packed {
    logic             vld;
    logic             flip;
    logic [TAG_W-1:0] tag;
  } smea_scl_req_t;

  typedef struct packed {
    logic             vld;
    logic [TAG_W-1:0] tag;
  } smea_scl_rsp_t;

endpackage

/* rtl/smea_if.sv */
// ----------------------------------------------------------------------------
// smea_if
// item channels of the spin matrix element accumulator
// ----------------------------------------------------------------------------
interface smea_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_up_re;
  logic signed [SAMPLE_BITS-1:0] left_up_im;
  logic signed [SAMPLE_BITS-1:0] left_dn_re;
  logic signed [SAMPLE_BITS-1:0] left_dn_im;
  logic signed [SAMPLE_BITS-1:0] right_up_re;
  logic signed [SAMPLE_BITS-1:0] right_up_im;
  logic signed [SAMPLE_BITS-1:0] right_dn_re;
  logic signed [SAMPLE_BITS-1:0] right_dn_im;
  logic                          last_point;

  modport source (
    output valid, left_up_re, left_up_im, left_dn_re, left_dn_im,
           right_up_re, right_up_im, right_dn_re, right_dn_im, last_point,
    input  ready
  );
  modport sink (
    input  valid, left_up_re, left_up_im, left_dn_re, left_dn_im,
           right_up_re, right_up_im, right_dn_re, right_dn_im, last_point,
    output ready
  );
endinterface

interface smea_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [smea_pkg::OUT_W-1:0] spin_x_re;
  logic signed [smea_pkg::OUT_W-1:0] spin_x_im;
  logic signed [smea_pkg::OUT_W-1:0] spin_y_re;
  logic signed [smea_pkg::OUT_W-1:0] spin_y_im;
  logic signed [smea_pkg::OUT_W-1:0] spin_z_re;
  logic signed [smea_pkg::OUT_W-1:0] spin_z_im;

  modport source (
    output valid, spin_x_re, spin_x_im, spin_y_re, spin_y_im, spin_z_re, spin_z_im,
    input  ready
  );
  modport sink (
    input  valid, spin_x_re, spin_x_im, spin_y_re, spin_y_im, spin_z_re, spin_z_im,
    output ready
  );
endinterface

/* rtl/smea_front.sv */
// ----------------------------------------------------------------------------
// smea_front
// input side: takes grid points and queues them with their last-point class
// ----------------------------------------------------------------------------
module smea_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  smea_in_if.sink                in_ch,
  output logic [smea_pkg::N_SMP-1:0][SAMPLE_BITS-1:0] smp_o,
  output smea_pkg::smea_q_ctl_t  q_ctl_o,
  input  logic                   q_ready_i
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned ENT_W = smea_pkg::N_SMP * SAMPLE_BITS + 1;

  logic [ENT_W-1:0] mem_q [DEPTH];
  logic [ENT_W-1:0] entry;
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign entry = {in_ch.last_point,
                  in_ch.right_dn_im, in_ch.right_dn_re,
                  in_ch.right_up_im, in_ch.right_up_re,
                  in_ch.left_dn_im,  in_ch.left_dn_re,
                  in_ch.left_up_im,  in_ch.left_up_re};

  assign in_ch.ready  = (cnt_q != 2'(DEPTH));
  assign push         = in_ch.valid && in_ch.ready;
  assign q_ctl_o.vld  = (cnt_q != 2'd0);
  assign q_ctl_o.last = mem_q[rd_ptr_q][ENT_W-1];
  assign smp_o        = mem_q[rd_ptr_q][ENT_W-2:0];
  assign pop          = q_ctl_o.vld && q_ready_i;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= entry;
  end

endmodule

/* rtl/smea_scale.sv */
// ----------------------------------------------------------------------------
// smea_scale
// scales one accumulator by dv/2, rounds half away from zero, saturates
// ----------------------------------------------------------------------------
module smea_scale #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned ACC_BITS    = 56
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  smea_pkg::smea_scl_req_t         req_i,
  input  logic signed [ACC_BITS-1:0]      acc_i,
  input  logic [smea_pkg::DV_W-1:0]       dv_i,
  output smea_pkg::smea_scl_rsp_t         rsp_o,
  output logic [smea_pkg::OUT_W-1:0]      res_o
);

  localparam int unsigned OUT_SHIFT = 2 * SAMPLE_BITS - 15;
  localparam int unsigned HI_W  = ACC_BITS - 32;
  localparam int unsigned PL_W  = 32 + smea_pkg::DV_W;
  localparam int unsigned PH_W  = HI_W + smea_pkg::DV_W;
  localparam int unsigned SUM_W = ACC_BITS + smea_pkg::DV_W + 1;
  localparam int unsigned CMP_W = (SUM_W > smea_pkg::OUT_W + 1) ? SUM_W : smea_pkg::OUT_W + 1;

  smea_pkg::smea_scl_rsp_t ctl1_q, ctl2_q, ctl3_q;
  logic                    sgn1_q, sgn2_q, sgn3_q;
  logic [ACC_BITS-1:0]     mag_q, mag_d;
  logic [PL_W-1:0]         pl_q;
  logic [PH_W-1:0]         ph_q;
  logic [SUM_W-1:0]        sum_q;
  logic                    neg;
  logic [CMP_W-1:0]        shifted, lim;
  logic [smea_pkg::OUT_W-1:0] mag_out;

  assign neg   = acc_i[ACC_BITS-1];
  assign mag_d = neg ? $unsigned(-acc_i) : $unsigned(acc_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= '{vld: req_i.vld, tag: req_i.tag};
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  // magnitude, partial products, then round
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    sgn1_q <= neg ^ req_i.flip;
    pl_q   <= PL_W'(mag_q[31:0]) * PL_W'(dv_i);
    ph_q   <= PH_W'(mag_q[ACC_BITS-1:32]) * PH_W'(dv_i);
    sgn2_q <= sgn1_q;
    sum_q  <= (SUM_W'(ph_q) << 32) + SUM_W'(pl_q) + (SUM_W'(1) << (OUT_SHIFT - 1));
    sgn3_q <= sgn2_q;
  end

  // negative side may reach one more than positive side
  always_comb begin
    shifted = CMP_W'(sum_q) >> OUT_SHIFT;
    lim     = sgn3_q ? (CMP_W'(1) << (smea_pkg::OUT_W - 1))
                     : ((CMP_W'(1) << (smea_pkg::OUT_W - 1)) - CMP_W'(1));
    mag_out = (shifted > lim) ? lim[smea_pkg::OUT_W-1:0] : shifted[smea_pkg::OUT_W-1:0];
    res_o   = sgn3_q ? (~mag_out + smea_pkg::OUT_W'(1)) : mag_out;
  end

  assign rsp_o = ctl3_q;

endmodule

/* rtl/smea_back.sv */
// ----------------------------------------------------------------------------
// smea_back
// execution side: complex products, accumulation and result sequencing
// ----------------------------------------------------------------------------
module smea_back #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned ACC_BITS    = 56
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [smea_pkg::N_SMP-1:0][SAMPLE_BITS-1:0] smp_i,
  input  smea_pkg::smea_q_ctl_t  q_ctl_i,
  output logic                   q_ready_o,
  input  logic [smea_pkg::DV_W-1:0] dv_i,
  input  logic                   hole_i,
  smea_out_if.source             out_ch
);

  localparam int unsigned PW = 2 * SAMPLE_BITS;

  smea_pkg::smea_state_e state_q, state_d;

  logic [smea_pkg::N_SMP-1:0][SAMPLE_BITS-1:0] smp_q;
  logic                          last_q;
  logic signed [PW-1:0]          prod_q [smea_pkg::N_PROD];
  logic signed [PW-1:0]          prod_d [smea_pkg::N_PROD];
  logic signed [ACC_BITS-1:0]    ext    [smea_pkg::N_PROD];
  logic signed [ACC_BITS-1:0]    delta_q [smea_pkg::N_OUT];
  logic signed [ACC_BITS-1:0]    delta_d [smea_pkg::N_OUT];
  logic signed [ACC_BITS-1:0]    acc_q   [smea_pkg::N_OUT];
  logic signed [ACC_BITS-1:0]    are, aim, bre, bim, cre, cim, dre, dim;
  logic [smea_pkg::OUT_W-1:0]    res_q   [smea_pkg::N_OUT];
  logic [smea_pkg::TAG_W-1:0]    issue_q, res_cnt_q;
  logic                          out_valid_q;
  logic                          ld_smp, mul_en, sum_en, acc_en, finish, issue_last;

  smea_pkg::smea_scl_req_t       scl_req;
  smea_pkg::smea_scl_rsp_t       scl_rsp;
  logic [smea_pkg::OUT_W-1:0]    scl_res;

  function automatic logic signed [PW-1:0] smul(logic [SAMPLE_BITS-1:0] a,
                                                logic [SAMPLE_BITS-1:0] b);
    smul = PW'($signed(a)) * PW'($signed(b));
  endfunction

  // sixteen real products of the four conj(a)*b terms
  always_comb begin
    prod_d[0]  = smul(smp_q[smea_pkg::SMP_LDR], smp_q[smea_pkg::SMP_RUR]);
    prod_d[1]  = smul(smp_q[smea_pkg::SMP_LDI], smp_q[smea_pkg::SMP_RUI]);
    prod_d[2]  = smul(smp_q[smea_pkg::SMP_LDR], smp_q[smea_pkg::SMP_RUI]);
    prod_d[3]  = smul(smp_q[smea_pkg::SMP_LDI], smp_q[smea_pkg::SMP_RUR]);
    prod_d[4]  = smul(smp_q[smea_pkg::SMP_LUR], smp_q[smea_pkg::SMP_RDR]);
    prod_d[5]  = smul(smp_q[smea_pkg::SMP_LUI], smp_q[smea_pkg::SMP_RDI]);
    prod_d[6]  = smul(smp_q[smea_pkg::SMP_LUR], smp_q[smea_pkg::SMP_RDI]);
    prod_d[7]  = smul(smp_q[smea_pkg::SMP_LUI], smp_q[smea_pkg::SMP_RDR]);
    prod_d[8]  = smul(smp_q[smea_pkg::SMP_LUR], smp_q[smea_pkg::SMP_RUR]);
    prod_d[9]  = smul(smp_q[smea_pkg::SMP_LUI], smp_q[smea_pkg::SMP_RUI]);
    prod_d[10] = smul(smp_q[smea_pkg::SMP_LUR], smp_q[smea_pkg::SMP_RUI]);
    prod_d[11] = smul(smp_q[smea_pkg::SMP_LUI], smp_q[smea_pkg::SMP_RUR]);
    prod_d[12] = smul(smp_q[smea_pkg::SMP_LDR], smp_q[smea_pkg::SMP_RDR]);
    prod_d[13] = smul(smp_q[smea_pkg::SMP_LDI], smp_q[smea_pkg::SMP_RDI]);
    prod_d[14] = smul(smp_q[smea_pkg::SMP_LDR], smp_q[smea_pkg::SMP_RDI]);
    prod_d[15] = smul(smp_q[smea_pkg::SMP_LDI], smp_q[smea_pkg::SMP_RDR]);
  end

  // per-point contributions, wrapping at the accumulator width
  always_comb begin
    for (int k = 0; k < smea_pkg::N_PROD; k++) begin
      ext[k] = ACC_BITS'(prod_q[k]);
    end
    are = ext[0] + ext[1];
    aim = ext[2] - ext[3];
    bre = ext[4] + ext[5];
    bim = ext[6] - ext[7];
    cre = ext[8] + ext[9];
    cim = ext[10] - ext[11];
    dre = ext[12] + ext[13];
    dim = ext[14] - ext[15];
    delta_d[smea_pkg::OUT_XR] = are + bre;
    delta_d[smea_pkg::OUT_XI] = aim + bim;
    delta_d[smea_pkg::OUT_YR] = bim - aim;
    delta_d[smea_pkg::OUT_YI] = are - bre;
    delta_d[smea_pkg::OUT_ZR] = cre - dre;
    delta_d[smea_pkg::OUT_ZI] = cim - dim;
  end

  assign issue_last = (issue_q == smea_pkg::TAG_W'(smea_pkg::N_OUT - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      smea_pkg::ST_IDLE:  if (q_ctl_i.vld) state_d = smea_pkg::ST_MUL;
      smea_pkg::ST_MUL:   state_d = smea_pkg::ST_SUM;
      smea_pkg::ST_SUM:   state_d = smea_pkg::ST_ACC;
      smea_pkg::ST_ACC:   state_d = last_q ? smea_pkg::ST_WAIT : smea_pkg::ST_IDLE;
      smea_pkg::ST_WAIT:  if (!out_valid_q) state_d = smea_pkg::ST_SCALE;
      smea_pkg::ST_SCALE: if (issue_last) state_d = smea_pkg::ST_DRAIN;
      smea_pkg::ST_DRAIN: if (finish) state_d = smea_pkg::ST_IDLE;
      default:            state_d = smea_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_ready_o = (state_q == smea_pkg::ST_IDLE);
    ld_smp    = q_ready_o && q_ctl_i.vld;
    mul_en    = (state_q == smea_pkg::ST_MUL);
    sum_en    = (state_q == smea_pkg::ST_SUM);
    acc_en    = (state_q == smea_pkg::ST_ACC);
    finish    = (state_q == smea_pkg::ST_DRAIN) &&
                (res_cnt_q == smea_pkg::TAG_W'(smea_pkg::N_OUT));
    scl_req.vld  = (state_q == smea_pkg::ST_SCALE);
    scl_req.tag  = issue_q;
    scl_req.flip = hole_i && !issue_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smea_pkg::ST_IDLE;
      issue_q     <= '0;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < smea_pkg::N_OUT; k++) acc_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == smea_pkg::ST_WAIT) issue_q <= '0;
      else if (scl_req.vld) issue_q <= issue_q + smea_pkg::TAG_W'(1);
      if (finish) res_cnt_q <= '0;
      else if (scl_rsp.vld) res_cnt_q <= res_cnt_q + smea_pkg::TAG_W'(1);
      if (finish) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
      if (finish) begin
        for (int k = 0; k < smea_pkg::N_OUT; k++) acc_q[k] <= '0;
      end else if (acc_en) begin
        for (int k = 0; k < smea_pkg::N_OUT; k++) acc_q[k] <= acc_q[k] + delta_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_smp) begin
      smp_q  <= smp_i;
      last_q <= q_ctl_i.last;
    end
    if (mul_en) begin
      for (int k = 0; k < smea_pkg::N_PROD; k++) prod_q[k] <= prod_d[k];
    end
    if (sum_en) begin
      for (int k = 0; k < smea_pkg::N_OUT; k++) delta_q[k] <= delta_d[k];
    end
    if (scl_rsp.vld) res_q[scl_rsp.tag] <= scl_res;
  end

  smea_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scl_req),
    .acc_i  (acc_q[issue_q]),
    .dv_i   (dv_i),
    .rsp_o  (scl_rsp),
    .res_o  (scl_res)
  );

  assign out_ch.valid     = out_valid_q;
  assign out_ch.spin_x_re = res_q[smea_pkg::OUT_XR];
  assign out_ch.spin_x_im = res_q[smea_pkg::OUT_XI];
  assign out_ch.spin_y_re = res_q[smea_pkg::OUT_YR];
  assign out_ch.spin_y_im = res_q[smea_pkg::OUT_YI];
  assign out_ch.spin_z_re = res_q[smea_pkg::OUT_ZR];
  assign out_ch.spin_z_im = res_q[smea_pkg::OUT_ZI];

endmodule

/* rtl/spin_matrix_element_accumulator.sv */
// ----------------------------------------------------------------------------
// spin_matrix_element_accumulator
// pauli spin matrix elements between two two-component states on a grid
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one grid point per item: bra and ket spin-up/spin-down
//   amplitudes plus last_point. out_ch carries one item per state pair,
//   the six Sx/Sy/Sz parts scaled by dv/2, saturated to 48 bits.
//   cfg_we_i/cfg_idx_i/cfg_data_i write volume_element (index 0) and
//   hole_mode (index 1); write only while the block is idle.
// timing
//   a two-entry queue takes points at up to one per cycle while it is not
//   full; the back end takes each point through pop, multiply, combine and
//   accumulate before it pops the next one
//   a last point also waits for a free output register, then the six sums
//   go through the shared scaling pipeline one per cycle, and the result
//   item becomes valid after all six scaled sums are back in the back end
// reset and stall
//   reset empties the queue, clears the accumulators, sets dv to 1.0 and
//   hole mode off. a result waits in the output register while out_ch is
//   stalled; later points keep accumulating, and the next last point holds
//   in the back end until the waiting result is taken
// ----------------------------------------------------------------------------
module spin_matrix_element_accumulator #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned ACC_BITS    = 56
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [smea_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [smea_pkg::DV_W-1:0]          cfg_data_i,
  smea_in_if.sink                            in_ch,
  smea_out_if.source                         out_ch
);

  // configuration registers
  logic [smea_pkg::DV_W-1:0] dv_q;
  logic                      hole_q;

  // queue to back end
  logic [smea_pkg::N_SMP-1:0][SAMPLE_BITS-1:0] q_smp;
  smea_pkg::smea_q_ctl_t     q_ctl;
  logic                      q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q   <= smea_pkg::DV_RESET;
      hole_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smea_pkg::CFG_VOLUME_ELEMENT: dv_q   <= cfg_data_i;
        smea_pkg::CFG_HOLE_MODE:      hole_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front: accept and queue points
  smea_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .smp_o     (q_smp),
    .q_ctl_o   (q_ctl),
    .q_ready_i (q_ready)
  );

  // back: products, accumulators, scaling and output register
  smea_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .smp_i     (q_smp),
    .q_ctl_i   (q_ctl),
    .q_ready_o (q_ready),
    .dv_i      (dv_q),
    .hole_i    (hole_q),
    .out_ch    (out_ch)
  );

endmodule
